// File: sv/bpa_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the bitmap page allocator. No dependencies.
package bpa_pkg;

  localparam int PAGES  = 4096;
  localparam int IDX_W  = $clog2(PAGES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int PAGE_W = 36;
  localparam int CAND_W = 18;
  localparam int MASK_W = 16;

  // request types
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_RANGE = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_OOM         = 3'd1;
  localparam logic [2:0] ST_BAD_RANGE   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;
  localparam logic [2:0] ST_BAD_COUNT   = 3'd5;

  // configuration register indexes
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_PAGES = 1'b1;

  // datapath operations
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_CLR     = 4'd1;
  localparam logic [3:0] OP_CAPTURE = 4'd2;
  localparam logic [3:0] OP_SETUP1  = 4'd3;
  localparam logic [3:0] OP_SETUP2  = 4'd4;
  localparam logic [3:0] OP_SETUP3  = 4'd5;
  localparam logic [3:0] OP_CAND    = 4'd6;
  localparam logic [3:0] OP_FINIT   = 4'd7;
  localparam logic [3:0] OP_RD      = 4'd8;
  localparam logic [3:0] OP_SCAN_EV = 4'd9;
  localparam logic [3:0] OP_MARK    = 4'd10;
  localparam logic [3:0] OP_FCHK_EV = 4'd11;
  localparam logic [3:0] OP_FCLR    = 4'd12;
  localparam logic [3:0] OP_Q_EV    = 4'd13;

  typedef struct packed {
    logic [3:0] op;
    logic       set_st;
    logic [2:0] st;
    logic       load_out;
  } bpa_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       clr_last;
    logic       cnt_zero;
    logic       n_zero;
    logic       range_rev;
    logic       win_empty;
    logic       free_bad;
    logic       cand_fit;
    logic       bit_set;
    logic       run_last;
    logic       q_last;
    logic       out_busy;
  } bpa_stat_t;

endpackage

// File: sv/bpa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int W     = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [W-1:0]             wdata,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/bpa_ctrl.sv
// Sequencer for the page allocator: steps the datapath through clear, setup,
// scan, mark, free check, release and count passes. Depends on bpa_pkg.
module bpa_ctrl import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bpa_stat_t stat,
  output bpa_cmd_t  cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SET1 = 4'd2;
  localparam logic [3:0] S_SET2 = 4'd3;
  localparam logic [3:0] S_SET3 = 4'd4;
  localparam logic [3:0] S_DISP = 4'd5;
  localparam logic [3:0] S_CAND = 4'd6;
  localparam logic [3:0] S_SRD  = 4'd7;
  localparam logic [3:0] S_SEV  = 4'd8;
  localparam logic [3:0] S_MARK = 4'd9;
  localparam logic [3:0] S_FRD  = 4'd10;
  localparam logic [3:0] S_FEV  = 4'd11;
  localparam logic [3:0] S_FCLR = 4'd12;
  localparam logic [3:0] S_QRD  = 4'd13;
  localparam logic [3:0] S_QEV  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.set_st   = 1'b0;
    cmd.st       = ST_OK;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_SET1;
        end
      end
      S_SET1: begin
        cmd.op    = OP_SETUP1;
        state_nxt = S_SET2;
      end
      S_SET2: begin
        cmd.op    = OP_SETUP2;
        state_nxt = S_SET3;
      end
      S_SET3: begin
        cmd.op    = OP_SETUP3;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        priority if (stat.req_type == REQ_QUERY) begin
          state_nxt = stat.n_zero ? S_DONE : S_QRD;
        end else if (stat.cnt_zero) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_BAD_COUNT;
          state_nxt  = S_DONE;
        end else if (stat.req_type == REQ_ALLOC) begin
          state_nxt = S_CAND;
        end else if (stat.req_type == REQ_RANGE) begin
          priority if (stat.range_rev) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_BAD_RANGE;
            state_nxt  = S_DONE;
          end else if (stat.win_empty) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_OOM;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_CAND;
          end
        end else begin
          if (stat.free_bad) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end else begin
            cmd.op    = OP_FINIT;
            state_nxt = S_FRD;
          end
        end
      end
      S_CAND: begin
        cmd.op    = OP_CAND;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        if (!stat.cand_fit) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_OOM;
          state_nxt  = S_DONE;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_SEV;
        end
      end
      S_SEV: begin
        cmd.op    = OP_SCAN_EV;
        state_nxt = (!stat.bit_set && stat.run_last) ? S_MARK : S_SRD;
      end
      S_MARK: begin
        cmd.op = OP_MARK;
        if (stat.run_last) state_nxt = S_DONE;
      end
      S_FRD: begin
        cmd.op    = OP_RD;
        state_nxt = S_FEV;
      end
      S_FEV: begin
        cmd.op = OP_FCHK_EV;
        priority if (!stat.bit_set) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_DOUBLE_FREE;
          state_nxt  = S_DONE;
        end else if (stat.run_last) begin
          state_nxt = S_FCLR;
        end else begin
          state_nxt = S_FRD;
        end
      end
      S_FCLR: begin
        cmd.op = OP_FCLR;
        if (stat.run_last) state_nxt = S_DONE;
      end
      S_QRD: begin
        cmd.op    = OP_RD;
        state_nxt = S_QEV;
      end
      S_QEV: begin
        cmd.op    = OP_Q_EV;
        state_nxt = stat.q_last ? S_DONE : S_QRD;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

endmodule

// File: sv/bpa_dp.sv
// Datapath of the page allocator: config and request registers, window
// arithmetic, scan counters, page bitmap and result register.
// Depends on bpa_pkg and bpa_ram.
module bpa_dp import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  bpa_cmd_t          cmd,
  output bpa_stat_t         stat,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [PAGE_W-1:0] cfg_wdata,
  input  logic [1:0]        in_req_type,
  input  logic [CNT_W-1:0]  in_page_count,
  input  logic [3:0]        in_align_log2,
  input  logic [PAGE_W-1:0] in_range_lo_page,
  input  logic [PAGE_W-1:0] in_range_hi_page,
  input  logic [PAGE_W-1:0] in_free_start_page,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [PAGE_W-1:0] out_start_page,
  output logic [CNT_W-1:0]  out_free_count
);

  // configuration
  logic [PAGE_W-1:0] base_r;
  logic [CNT_W-1:0]  rpages_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      rpages_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE) base_r <= cfg_wdata;
      else rpages_r <= cfg_wdata[CNT_W-1:0];
    end
  end

  // request
  logic [1:0]        type_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [3:0]        alog_r;
  logic [PAGE_W-1:0] lo_r, hi_r, fs_r;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      type_r <= in_req_type;
      cnt_r  <= in_page_count;
      alog_r <= in_align_log2;
      lo_r   <= in_range_lo_page;
      hi_r   <= in_range_hi_page;
      fs_r   <= in_free_start_page;
    end
  end

  // setup registers
  logic [CNT_W-1:0]  n_r;
  logic [MASK_W-1:0] d_r;
  logic [PAGE_W:0]   ws_r, we_r, off_r;
  logic              below_r, rev_r, empty_r, fbad_r;
  logic [CNT_W-1:0]  wlo_r, whi_r;

  logic [MASK_W-1:0] mask;
  logic [PAGE_W:0]   room, bpn, ws_up, we_dn, mask_w;
  logic [CNT_W-1:0]  n_cap;
  logic [PAGE_W:0]   n_w, cnt_w;

  assign mask   = ~({MASK_W{1'b1}} << alog_r);
  assign mask_w = {{(PAGE_W+1-MASK_W){1'b0}}, mask};
  assign room   = {1'b1, {PAGE_W{1'b0}}} - {1'b0, base_r};
  assign n_cap  = (rpages_r > CNT_W'(PAGES)) ? CNT_W'(PAGES) : rpages_r;
  assign n_w    = {{(PAGE_W+1-CNT_W){1'b0}}, n_r};
  assign cnt_w  = {{(PAGE_W+1-CNT_W){1'b0}}, cnt_r};
  assign bpn    = {1'b0, base_r} + n_w;
  assign ws_up  = (ws_r + mask_w) & ~mask_w;
  assign we_dn  = we_r & ~mask_w;

  // scan counters
  logic [CAND_W-1:0] cand_r, cand_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [CNT_W-1:0]  fcnt_r;
  logic [2:0]        st_r;
  logic [CAND_W-1:0] pos, pos1, up_sum, d_c, m_c;
  logic              bit_q;

  assign pos    = cand_r + {{(CAND_W-CNT_W){1'b0}}, run_r};
  assign pos1   = pos + CAND_W'(1);
  assign d_c    = {{(CAND_W-MASK_W){1'b0}}, d_r};
  assign m_c    = {{(CAND_W-MASK_W){1'b0}}, mask};
  // round an index up to the next absolute alignment boundary
  assign up_sum = ((pos1 + d_c + m_c) & ~m_c) - d_c;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_SETUP1: begin
        n_r   <= (room < {{(PAGE_W+1-CNT_W){1'b0}}, n_cap}) ? room[CNT_W-1:0] : n_cap;
        d_r   <= base_r[MASK_W-1:0] & mask;
        rev_r <= lo_r > hi_r;
      end
      OP_SETUP2: begin
        ws_r    <= (lo_r > base_r) ? {1'b0, lo_r} : {1'b0, base_r};
        we_r    <= ({1'b0, hi_r} < bpn) ? {1'b0, hi_r} : bpn;
        below_r <= fs_r < base_r;
        off_r   <= {1'b0, fs_r} - {1'b0, base_r};
      end
      OP_SETUP3: begin
        empty_r <= !(ws_up < we_dn);
        fbad_r  <= below_r || (off_r > n_w) || (cnt_w > n_w - off_r);
        if (type_r == REQ_RANGE) begin
          wlo_r <= CNT_W'(ws_up - {1'b0, base_r});
          whi_r <= CNT_W'(we_dn - {1'b0, base_r});
        end else begin
          wlo_r <= '0;
          whi_r <= n_r;
        end
      end
      default: ;
    endcase
  end

  // page bitmap
  logic             ram_we, ram_wd;
  logic [IDX_W-1:0] ram_addr;

  bpa_ram #(.W(1), .DEPTH(PAGES)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (bit_q)
  );

  always_comb begin
    ram_we   = 1'b0;
    ram_wd   = 1'b0;
    ram_addr = pos[IDX_W-1:0];
    unique case (cmd.op)
      OP_CLR: begin
        ram_we   = 1'b1;
        ram_addr = run_r[IDX_W-1:0];
      end
      OP_MARK: begin
        ram_we = 1'b1;
        ram_wd = 1'b1;
      end
      OP_FCLR: ram_we = 1'b1;
      default: ;
    endcase
  end

  logic run_last;
  assign run_last = (run_r + CNT_W'(1)) == cnt_r;

  always_comb begin
    cand_nxt = cand_r;
    run_nxt  = run_r;
    unique case (cmd.op)
      OP_CLR, OP_MARK, OP_FCLR, OP_Q_EV: run_nxt = run_r + CNT_W'(1);
      OP_SETUP1: begin
        cand_nxt = '0;
        run_nxt  = '0;
      end
      OP_CAND: begin
        cand_nxt = ((({{(CAND_W-CNT_W){1'b0}}, wlo_r}) + d_c + m_c) & ~m_c) - d_c;
        run_nxt  = '0;
      end
      OP_FINIT: begin
        cand_nxt = {{(CAND_W-CNT_W){1'b0}}, off_r[CNT_W-1:0]};
        run_nxt  = '0;
      end
      OP_SCAN_EV: begin
        if (bit_q) begin
          cand_nxt = up_sum;
          run_nxt  = '0;
        end else begin
          run_nxt = run_last ? '0 : run_r + CNT_W'(1);
        end
      end
      OP_FCHK_EV: run_nxt = run_last ? '0 : run_r + CNT_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
    cand_r <= cand_nxt;
    if (cmd.op == OP_SETUP1) fcnt_r <= '0;
    else if (cmd.op == OP_Q_EV && !bit_q) fcnt_r <= fcnt_r + CNT_W'(1);
    if (cmd.op == OP_CAPTURE) st_r <= ST_OK;
    else if (cmd.set_st) st_r <= cmd.st;
  end

  // result register
  logic              ov_r;
  logic [2:0]        ost_r;
  logic [PAGE_W-1:0] ostart_r;
  logic [CNT_W-1:0]  ofree_r;
  logic              granted;
  logic [PAGE_W:0]   abs_start;

  assign granted   = (st_r == ST_OK) && (type_r == REQ_ALLOC || type_r == REQ_RANGE);
  assign abs_start = {1'b0, base_r} + {{(PAGE_W+1-CAND_W){1'b0}}, cand_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load_out) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
    if (cmd.load_out) begin
      ost_r    <= st_r;
      ostart_r <= granted ? abs_start[PAGE_W-1:0] : '0;
      ofree_r  <= (type_r == REQ_QUERY) ? fcnt_r : '0;
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = ost_r;
  assign out_start_page = ostart_r;
  assign out_free_count = ofree_r;

  // status to the sequencer
  assign stat.req_type  = type_r;
  assign stat.clr_last  = run_r == CNT_W'(PAGES - 1);
  assign stat.cnt_zero  = cnt_r == '0;
  assign stat.n_zero    = n_r == '0;
  assign stat.range_rev = rev_r;
  assign stat.win_empty = empty_r;
  assign stat.free_bad  = fbad_r;
  assign stat.cand_fit  = ({1'b0, cand_r} + {{(CAND_W+1-CNT_W){1'b0}}, cnt_r})
                          <= {{(CAND_W+1-CNT_W){1'b0}}, whi_r};
  assign stat.bit_set   = bit_q;
  assign stat.run_last  = run_last;
  assign stat.q_last    = (run_r + CNT_W'(1)) == n_r;
  assign stat.out_busy  = ov_r && !out_ready;

endmodule

// File: sv/bitmap_page_allocator_core.sv
// Top level of the bitmap first-fit page allocator.
// Depends on bpa_pkg, bpa_ctrl, bpa_dp (which holds bpa_ram).
//
//  Channel | Ports                                   | Moves
//  --------+-----------------------------------------+------------------------
//  in      | in_valid/in_ready + six request fields  | one request
//  out     | out_valid/out_ready + status/start/free | one result per request
//  cfg     | cfg_we, cfg_index, cfg_wdata            | base page, region pages
//
// After reset the page bitmap is swept clear, one page a cycle, all 4096 pages
// with in_ready low (config writes still taken).
// A request is accepted in idle, passes setup states SET1-SET3 and dispatch;
// allocations add a state to place the first candidate and a last check when
// the search fails. Each page read by the first-fit scan, free check or free
// count takes a read and an evaluate state (single-port bitmap RAM with
// registered read); each page marked or released takes a state of its own;
// the result is loaded in the done state. The result register frees the
// sequencer; a stalled out_ready only holds the next request in its done state.
module bitmap_page_allocator_core import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [CNT_W-1:0]  in_page_count,
  input  logic [3:0]        in_align_log2,
  input  logic [PAGE_W-1:0] in_range_lo_page,
  input  logic [PAGE_W-1:0] in_range_hi_page,
  input  logic [PAGE_W-1:0] in_free_start_page,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [PAGE_W-1:0] out_start_page,
  output logic [CNT_W-1:0]  out_free_count,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [PAGE_W-1:0] cfg_wdata
);

  bpa_cmd_t  cmd;
  bpa_stat_t stat;

  // sequencer: accept a request, then step the datapath through it
  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: registers, window arithmetic, bitmap and result register
  bpa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_req_type        (in_req_type),
    .in_page_count      (in_page_count),
    .in_align_log2      (in_align_log2),
    .in_range_lo_page   (in_range_lo_page),
    .in_range_hi_page   (in_range_hi_page),
    .in_free_start_page (in_free_start_page),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_start_page     (out_start_page),
    .out_free_count     (out_free_count)
  );

endmodule
